>>> src/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg: shared definitions for the range to file span mapper
// Field widths, stream packing positions, result codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int MAX_FILES   = 64;
    localparam int OFFSET_BITS = 48;
    localparam int LEN_BITS    = 32;
    localparam int IDX_BITS    = 6;
    localparam int CNT_BITS    = 7;
    localparam int STATUS_BITS = 2;

    // Input transaction payload, lowest bit first
    localparam int S_IDX_LSB   = 0;
    localparam int S_START_LSB = S_IDX_LSB + IDX_BITS;
    localparam int S_ELEN_LSB  = S_START_LSB + OFFSET_BITS;
    localparam int S_OFF_LSB   = S_ELEN_LSB + OFFSET_BITS;
    localparam int S_RLEN_LSB  = S_OFF_LSB + OFFSET_BITS;
    localparam int S_USED_BITS = S_RLEN_LSB + LEN_BITS;
    localparam int S_DATA_BITS = ((S_USED_BITS + 7) / 8) * 8;

    // Result transaction payload, lowest bit first
    localparam int M_IDX_LSB   = 0;
    localparam int M_LOC_LSB   = M_IDX_LSB + IDX_BITS;
    localparam int M_LEN_LSB   = M_LOC_LSB + OFFSET_BITS;
    localparam int M_USED_BITS = M_LEN_LSB + LEN_BITS;
    localparam int M_DATA_BITS = ((M_USED_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = OFFSET_BITS;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPACE_SIZE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILE_COUNT = 1'b1;

    // Input kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_RANGE     = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic load_we;
        logic req_capture;
        logic check;
        logic rd_search;
        logic srch_update;
        logic rd_walk;
        logic idx_inc;
        logic calc_local;
        logic calc_chunk;
        logic emit_span;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic range_bad;
        logic len_zero;
        logic search_done;
        logic walk_done;
        logic file_empty;
        logic pend_valid;
        logic out_free;
    } sts_t;

endpackage

>>> src/trs_ctrl.sv
// ----------------------------------------------------------------------------
// trs_ctrl: request sequencer
// Steps one item at a time through range check, binary search and the
// forward walk, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module trs_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          s_tuser,   // kind
    input  trs_pkg::sts_t sts,
    output trs_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CHECK   = 4'd1;
    localparam logic [3:0] ST_S_ADDR  = 4'd2;
    localparam logic [3:0] ST_S_CMP   = 4'd3;
    localparam logic [3:0] ST_W_ADDR  = 4'd4;
    localparam logic [3:0] ST_W_EVAL  = 4'd5;
    localparam logic [3:0] ST_W_CHUNK = 4'd6;
    localparam logic [3:0] ST_W_EMIT  = 4'd7;
    localparam logic [3:0] ST_FINISH  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load_we     = accept && (s_tuser == trs_pkg::KIND_LOAD);
                cmd.req_capture = accept && (s_tuser == trs_pkg::KIND_REQUEST);
                if (cmd.req_capture) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
                if (sts.range_bad || sts.len_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_S_ADDR;
                end
            end
            ST_S_ADDR: begin
                if (sts.search_done) begin
                    state_next = ST_W_ADDR;
                end else begin
                    cmd.rd_search = 1'b1;
                    state_next    = ST_S_CMP;
                end
            end
            ST_S_CMP: begin
                cmd.srch_update = 1'b1;
                state_next      = ST_S_ADDR;
            end
            ST_W_ADDR: begin
                if (sts.walk_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.rd_walk = 1'b1;
                    state_next  = ST_W_EVAL;
                end
            end
            ST_W_EVAL: begin
                if (sts.file_empty) begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_W_ADDR;
                end else begin
                    cmd.calc_local = 1'b1;
                    state_next     = ST_W_CHUNK;
                end
            end
            ST_W_CHUNK: begin
                cmd.calc_chunk = 1'b1;
                state_next     = ST_W_EMIT;
            end
            ST_W_EMIT: begin
                if (!sts.pend_valid || sts.out_free) begin
                    cmd.emit_span = 1'b1;
                    state_next    = ST_W_ADDR;
                end
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/trs_datapath.sv
// ----------------------------------------------------------------------------
// trs_datapath: file table, search and walk registers, result register
// Holds the table memories, configuration, the search bounds and walk
// cursor, one pending span and the output register.
// ----------------------------------------------------------------------------
module trs_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [trs_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [trs_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  logic [trs_pkg::S_DATA_BITS-1:0]       s_tdata,
    input  trs_pkg::cmd_t                         cmd,
    output trs_pkg::sts_t                         sts,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [trs_pkg::M_DATA_BITS-1:0]       m_tdata,
    output logic [trs_pkg::STATUS_BITS-1:0]       m_tuser,
    output logic                                  m_tlast
);

    localparam int OB = trs_pkg::OFFSET_BITS;
    localparam int LB = trs_pkg::LEN_BITS;
    localparam int IB = trs_pkg::IDX_BITS;
    localparam int CB = trs_pkg::CNT_BITS;
    localparam int SB = trs_pkg::STATUS_BITS;

    logic [OB-1:0] mem_start [0:trs_pkg::MAX_FILES-1];
    logic [OB-1:0] mem_len   [0:trs_pkg::MAX_FILES-1];
    logic [OB-1:0] rd_start_reg;
    logic [OB-1:0] rd_len_reg;

    logic [OB-1:0] space_size_reg;
    logic [CB-1:0] file_count_reg;
    logic [CB-1:0] count_reg;
    logic [OB-1:0] off_reg;
    logic [LB-1:0] len_reg;
    logic          err_reg;

    logic [CB-1:0] lo_reg;
    logic [CB-1:0] hi_reg;
    logic [CB-1:0] mid_reg;
    logic [CB:0]   mid_sum;
    logic [CB-1:0] mid;
    logic [IB-1:0] rd_addr;

    logic [OB:0]   end_sum;
    logic [OB-1:0] end_sat;
    logic          go_right;

    logic [OB-1:0] cursor_reg;
    logic [LB-1:0] left_reg;
    logic [OB-1:0] local_reg;
    logic [OB-1:0] flen_reg;
    logic [LB-1:0] chunk_reg;
    logic [OB-1:0] avail;

    logic          pend_valid_reg;
    logic [IB-1:0] pend_idx_reg;
    logic [OB-1:0] pend_local_reg;
    logic [LB-1:0] pend_len_reg;

    logic          out_valid_reg;
    logic [IB-1:0] out_idx_reg;
    logic [OB-1:0] out_local_reg;
    logic [LB-1:0] out_len_reg;
    logic [SB-1:0] out_status_reg;
    logic          out_last_reg;
    logic          out_free;
    logic          push_mid;
    logic [SB-1:0] fin_status;
    logic [CB-1:0] sat_count;

    // Table memories: one write port from load items, one registered read
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CB:1];
    assign rd_addr = cmd.rd_search ? mid[IB-1:0] : lo_reg[IB-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            mem_start[s_tdata[trs_pkg::S_IDX_LSB +: IB]] <=
                s_tdata[trs_pkg::S_START_LSB +: OB];
            mem_len[s_tdata[trs_pkg::S_IDX_LSB +: IB]] <=
                s_tdata[trs_pkg::S_ELEN_LSB +: OB];
        end
        if (cmd.rd_search || cmd.rd_walk) begin
            rd_start_reg <= mem_start[rd_addr];
            rd_len_reg   <= mem_len[rd_addr];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            space_size_reg <= '0;
            file_count_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                trs_pkg::REG_SPACE_SIZE: space_size_reg <= cfg_wdata[OB-1:0];
                trs_pkg::REG_FILE_COUNT: file_count_reg <= cfg_wdata[CB-1:0];
                default: ;
            endcase
        end
    end

    assign sat_count = (file_count_reg > CB'(trs_pkg::MAX_FILES)) ?
                       CB'(trs_pkg::MAX_FILES) : file_count_reg;

    // File end, saturated on carry, against the request offset
    assign end_sum  = {1'b0, rd_start_reg} + {1'b0, rd_len_reg};
    assign end_sat  = end_sum[OB] ? {OB{1'b1}} : end_sum[OB-1:0];
    assign go_right = (end_sat <= off_reg);

    assign avail = flen_reg - local_reg;

    always_ff @(posedge aclk) begin
        if (cmd.req_capture) begin
            off_reg   <= s_tdata[trs_pkg::S_OFF_LSB +: OB];
            len_reg   <= s_tdata[trs_pkg::S_RLEN_LSB +: LB];
            count_reg <= sat_count;
        end
        if (cmd.check) begin
            err_reg    <= sts.range_bad;
            lo_reg     <= '0;
            hi_reg     <= count_reg;
            cursor_reg <= off_reg;
            left_reg   <= len_reg;
        end
        if (cmd.rd_search) begin
            mid_reg <= mid;
        end
        if (cmd.srch_update) begin
            if (go_right) begin
                lo_reg <= mid_reg + CB'(1);
            end else begin
                hi_reg <= mid_reg;
            end
        end
        if (cmd.idx_inc) begin
            lo_reg <= lo_reg + CB'(1);
        end
        if (cmd.calc_local) begin
            local_reg <= cursor_reg - rd_start_reg;
            flen_reg  <= rd_len_reg;
        end
        if (cmd.calc_chunk) begin
            chunk_reg <= (avail < {{(OB-LB){1'b0}}, left_reg}) ? avail[LB-1:0] : left_reg;
        end
        if (cmd.emit_span) begin
            pend_idx_reg   <= lo_reg[IB-1:0];
            pend_local_reg <= local_reg;
            pend_len_reg   <= chunk_reg;
            cursor_reg     <= cursor_reg + {{(OB-LB){1'b0}}, chunk_reg};
            left_reg       <= left_reg - chunk_reg;
            lo_reg         <= lo_reg + CB'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.check || cmd.finish) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.emit_span) begin
            pend_valid_reg <= 1'b1;
        end
    end

    // Result register
    assign out_free = !out_valid_reg || m_tready;
    assign push_mid = cmd.emit_span && pend_valid_reg;

    always_comb begin
        if (pend_valid_reg || !err_reg) begin
            fin_status = (left_reg != '0) ? trs_pkg::STATUS_EXHAUSTED : trs_pkg::STATUS_OK;
        end else begin
            fin_status = trs_pkg::STATUS_RANGE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (push_mid || cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_mid) begin
            out_idx_reg    <= pend_idx_reg;
            out_local_reg  <= pend_local_reg;
            out_len_reg    <= pend_len_reg;
            out_status_reg <= trs_pkg::STATUS_OK;
            out_last_reg   <= 1'b0;
        end else if (cmd.finish) begin
            out_idx_reg    <= pend_valid_reg ? pend_idx_reg : '0;
            out_local_reg  <= pend_valid_reg ? pend_local_reg : '0;
            out_len_reg    <= pend_valid_reg ? pend_len_reg : '0;
            out_status_reg <= fin_status;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(trs_pkg::M_DATA_BITS - trs_pkg::M_USED_BITS){1'b0}},
                       out_len_reg, out_local_reg, out_idx_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // Status to the controller
    assign sts.range_bad   = (off_reg > space_size_reg) ||
                             ({{(OB-LB){1'b0}}, len_reg} > (space_size_reg - off_reg));
    assign sts.len_zero    = (len_reg == '0);
    assign sts.search_done = (lo_reg >= hi_reg);
    assign sts.walk_done   = (left_reg == '0) || (lo_reg >= count_reg);
    assign sts.file_empty  = (rd_len_reg == '0);
    assign sts.pend_valid  = pend_valid_reg;
    assign sts.out_free    = out_free;

`ifndef SYNTH
    a_span_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        push_mid |-> out_free)
        else $error("pending span pushed over a held result");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> out_free)
        else $error("final result pushed over a held result");

    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (m_tvalid && m_tlast))
        else $error("final result not presented with last");

    a_search_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_search |-> (lo_reg < hi_reg) && (hi_reg <= count_reg))
        else $error("search read outside its bounds");

    a_walk_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_walk |-> (lo_reg < count_reg) && (left_reg != '0))
        else $error("walk read past the valid entries");
`endif

endmodule

>>> src/torrent_range_to_file_spans.sv
// A load is written on accept. A request is accepted and checked; out of range or zero length
// goes to finish. Else a binary search (address, compare per step; at most ceil(log2(count+1))
// steps, 7 for 64 files) and a walk (read, evaluate, chunk and emit per non-empty file) precede
// finish. One item in flight; held results stall span emission and finish.
// Reset: aresetn low at a clock edge clears the sequencer, configuration, pending span and
// result valid; the file table is not cleared and holds whatever was last loaded.
// ----------------------------------------------------------------------------
// torrent_range_to_file_spans: byte range to file span mapper
// Maps an absolute byte range in a concatenated file space onto spans of the
// individual files held in a loadable table.
// ----------------------------------------------------------------------------
module torrent_range_to_file_spans (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // Configuration writes: index 0 space size, index 1 file_count
    input  logic                                  cfg_we,
    input  logic [trs_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [trs_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,

    // Input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // entry_index, entry_start, entry_length, request_offset, request_length, zero pad
    input  logic [trs_pkg::S_DATA_BITS-1:0]       s_tdata,
    // kind
    input  logic                                  s_tuser,

    // Result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // file_index, local_offset, span_length, zero pad
    output logic [trs_pkg::M_DATA_BITS-1:0]       m_tdata,
    // status
    output logic [trs_pkg::STATUS_BITS-1:0]       m_tuser,
    // last
    output logic                                  m_tlast
);

    trs_pkg::cmd_t cmd;
    trs_pkg::sts_t sts;

    // Sequencer: accept one transaction at a time; for a request, drive the check, search and walk
    trs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: hold the table, advance the cursor, and stage each span one
    // step behind so that the final one can carry last and its status
    trs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
